@@ sv/sscf_pkg.sv @@
// Shared types, constants and helpers for the case-folding substring search.
// Used by sscf_cell, sscf_chain and substring_search_casefold; no dependencies.
package sscf_pkg;

    // Longest pattern the cell row can hold, and the register layout.
    localparam int unsigned PATTERN_MAX = 32;
    localparam int unsigned PAT_WORDS   = 4;
    localparam int unsigned WORD_BYTES  = 8;
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd5;

    // ASCII folding bounds.
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'd32;

    // Control common to every cell of the row.
    typedef struct packed {
        logic advance;   // a text byte is accepted this cycle
        logic clear;     // the accepted byte ends the text
        logic usable;    // pattern length is within 1..PATTERN_MAX
        logic fold_en;   // fold ASCII A-Z to lower case
    } cell_ctrl_t;

    // Per-cell position information relative to the pattern length.
    typedef struct packed {
        logic active;    // cell index is below the pattern length
        logic tail;      // cell index is the last pattern byte
    } cell_lane_t;

    // Folds an upper-case ASCII letter to lower case when enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
        begin
            r = c + ASCII_CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ sv/sscf_cell.sv @@
// One position of the bit-parallel match vector: compares a pattern byte.
// Depends on sscf_pkg for the control structs and the folding function.
module sscf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sscf_pkg::cell_ctrl_t ctrl,
    input  sscf_pkg::cell_lane_t lane,
    input  logic [7:0]          pattern_byte,
    input  logic [7:0]          text_folded,
    input  logic                prev_bit,
    output logic                match_bit,
    output logic                hit
);

    logic partial_reg;
    logic partial_next;
    logic byte_eq;

    // Pattern bytes 0..j match the text bytes ending at the current byte.
    always_comb
    begin
        byte_eq      = (sscf_pkg::fold_byte(pattern_byte, ctrl.fold_en) == text_folded);
        partial_next = ctrl.usable & lane.active & prev_bit & byte_eq;
        hit          = ctrl.advance & lane.tail & partial_next;
    end

    // The bit is cleared once the text ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            partial_reg <= ctrl.clear ? 1'b0 : partial_next;
        end
    end

    assign match_bit = partial_reg;

endmodule

@@ sv/sscf_chain.sv @@
// Row of PATTERN_MAX match cells; each cell above cell 0 is fed by its lower neighbor's bit.
// Depends on sscf_pkg and sscf_cell.
module sscf_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  sscf_pkg::cell_ctrl_t ctrl,
    input  logic [sscf_pkg::LEN_W-1:0] pattern_len,
    input  logic [sscf_pkg::PAT_WORDS*sscf_pkg::CFG_DATA_W-1:0] pattern_bits,
    input  logic [7:0]          text_folded,
    output logic                hit,
    output logic                vector_zero
);

    logic [sscf_pkg::PATTERN_MAX-1:0] match_vec;
    logic [sscf_pkg::PATTERN_MAX-1:0] hit_vec;

    for (genvar j = 0; j < sscf_pkg::PATTERN_MAX; j++)
    begin : g_cell
        sscf_pkg::cell_lane_t lane;
        logic                 prev_bit;

        // Lane flags come from comparing the cell index with the length.
        always_comb
        begin
            lane.active = (sscf_pkg::LEN_W'(j) < pattern_len);
            lane.tail   = (sscf_pkg::LEN_W'(j + 1) == pattern_len);
        end

        if (j == 0)
        begin : g_head
            assign prev_bit = 1'b1;
        end
        else
        begin : g_link
            assign prev_bit = match_vec[j-1];
        end

        sscf_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .lane         (lane),
            .pattern_byte (pattern_bits[j*8 +: 8]),
            .text_folded  (text_folded),
            .prev_bit     (prev_bit),
            .match_bit    (match_vec[j]),
            .hit          (hit_vec[j])
        );
    end

    // At most one cell is the tail, so an OR gives the hit.
    assign hit         = |hit_vec;
    assign vector_zero = (match_vec == '0);

endmodule

@@ sv/substring_search_casefold.sv @@
// Top level of the streaming substring search with ASCII case folding.
// Depends on sscf_pkg and sscf_chain (which holds the sscf_cell row).
//
// Usage:
//   Configuration is written through cfg_write/cfg_index/cfg_data while the
//   block is idle: index 0 pattern length, 1 case-sensitive flag, 2..5 the
//   pattern words, lowest byte index in the low bits. Other indexes are ignored.
//   Text bytes arrive on the input channel (in_valid, in_stall, text_byte,
//   last_byte), one transaction per byte; last_byte marks the end of a text.
//   The last byte of each text yields one transaction on the output channel
//   (out_valid, out_stall, match_found, match_offset); other bytes yield none.
//   Throughput is one byte per cycle while in_stall is low: every cell of the
//   match row updates in the cycle that the byte is accepted. The result is
//   registered and shows in the cycle after the last byte is accepted.
//   While a result waits under out_stall, in_stall is raised; otherwise bytes
//   keep flowing even as a result is taken in the same cycle.
//   Reset sets pattern length 1, clears the other config registers, out_valid
//   and the per-text state; per-text state is also cleared after every last byte.
module substring_search_casefold (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sscf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sscf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          text_byte,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                match_found,
    output logic [sscf_pkg::POS_W-1:0]          match_offset
);

    localparam int unsigned PAT_BITS = sscf_pkg::PAT_WORDS * sscf_pkg::CFG_DATA_W;

    // Configuration registers.
    logic [sscf_pkg::LEN_W-1:0]      pattern_len_reg;
    logic                            case_sensitive_reg;
    logic [PAT_BITS-1:0]             pattern_reg;

    // Per-text state.
    logic [sscf_pkg::POS_W-1:0]      position_reg;
    logic [sscf_pkg::POS_W-1:0]      position_next;
    logic                            found_reg;
    logic [sscf_pkg::POS_W-1:0]      first_offset_reg;

    // Output stage.
    logic                            out_valid_reg;
    logic                            match_found_reg;
    logic [sscf_pkg::POS_W-1:0]      match_offset_reg;

    logic                            in_accept;
    logic                            out_accept;
    sscf_pkg::cell_ctrl_t            ctrl;
    logic [7:0]                      text_folded;
    logic                            hit;
    logic                            vector_zero;
    logic [sscf_pkg::POS_W-1:0]      start_offset;
    logic                            found_final;
    logic [sscf_pkg::POS_W-1:0]      offset_final;

    // Handshake: a waiting result blocks new bytes only while it is stalled.
    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg    <= sscf_pkg::LEN_W'(1);
            case_sensitive_reg <= 1'b0;
            pattern_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sscf_pkg::REG_PATTERN_LEN:
                    pattern_len_reg <= cfg_data[sscf_pkg::LEN_W-1:0];
                sscf_pkg::REG_CASE_SENSITIVE:
                    case_sensitive_reg <= cfg_data[0];
                sscf_pkg::REG_PATTERN_WORD_0:
                    pattern_reg[0*sscf_pkg::CFG_DATA_W +: sscf_pkg::CFG_DATA_W] <= cfg_data;
                sscf_pkg::REG_PATTERN_WORD_1:
                    pattern_reg[1*sscf_pkg::CFG_DATA_W +: sscf_pkg::CFG_DATA_W] <= cfg_data;
                sscf_pkg::REG_PATTERN_WORD_2:
                    pattern_reg[2*sscf_pkg::CFG_DATA_W +: sscf_pkg::CFG_DATA_W] <= cfg_data;
                sscf_pkg::REG_PATTERN_WORD_3:
                    pattern_reg[3*sscf_pkg::CFG_DATA_W +: sscf_pkg::CFG_DATA_W] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control shared by the cell row.
    always_comb
    begin
        ctrl.advance = in_accept;
        ctrl.clear   = last_byte;
        ctrl.usable  = (pattern_len_reg != '0) &&
                       (pattern_len_reg <= sscf_pkg::LEN_W'(sscf_pkg::PATTERN_MAX));
        ctrl.fold_en = ~case_sensitive_reg;
        text_folded  = sscf_pkg::fold_byte(text_byte, ~case_sensitive_reg);
    end

    sscf_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .pattern_len  (pattern_len_reg),
        .pattern_bits (pattern_reg),
        .text_folded  (text_folded),
        .hit          (hit),
        .vector_zero  (vector_zero)
    );

    // Start of a match ending at the current byte, and the text result.
    always_comb
    begin
        start_offset  = position_reg -
                        {{(sscf_pkg::POS_W-sscf_pkg::LEN_W){1'b0}},
                         pattern_len_reg - sscf_pkg::LEN_W'(1)};
        position_next = (position_reg == '1) ? position_reg
                                             : position_reg + sscf_pkg::POS_W'(1);
        found_final   = found_reg | hit;
        if (found_reg)
        begin
            offset_final = first_offset_reg;
        end
        else if (hit)
        begin
            offset_final = start_offset;
        end
        else
        begin
            offset_final = '0;
        end
    end

    // Position counter and first-match tracking; cleared after each text.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            found_reg        <= 1'b0;
            first_offset_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last_byte)
            begin
                position_reg     <= '0;
                found_reg        <= 1'b0;
                first_offset_reg <= '0;
            end
            else
            begin
                position_reg     <= position_next;
                found_reg        <= found_final;
                first_offset_reg <= offset_final;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with the result of the last byte.
    always_ff @(posedge clk)
    begin
        if (in_accept && last_byte)
        begin
            match_found_reg  <= found_final;
            match_offset_reg <= offset_final;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_found  = match_found_reg;
    assign match_offset = match_offset_reg;

    // A result appears only after an accepted last byte.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && last_byte))
        else $error("result raised without a last byte");

    // Per-text state is clear after a text ends.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (position_reg == '0 && !found_reg && vector_zero))
        else $error("per-text state not cleared after last byte");

    // A result without a match reports offset zero.
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !match_found_reg) |-> (match_offset_reg == '0))
        else $error("nonzero offset without a match");

    // A recorded match implies at least one byte of the text was consumed.
    a_found_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (position_reg != '0))
        else $error("match recorded before any byte");

endmodule
